/* hdl/fvc_pkg.sv */
// ----------------------------------------------------------------------------
// fvc_pkg: shared types, widths and codes of the frustum volume cull block
// Plane packing, volume payload, per-plane flags and verdict codes.
// ----------------------------------------------------------------------------
package fvc_pkg;

   localparam int COORD_WIDTH  = 28;                 // Q16.12 coordinates
   localparam int NORMAL_WIDTH = 12;                 // Q2.10 normals
   localparam int NORMAL_FRAC  = NORMAL_WIDTH - 2;
   localparam int RADIUS_WIDTH = COORD_WIDTH - 1;
   localparam int PLANE_COUNT  = 6;
   localparam int AXIS_COUNT   = 3;

   localparam int CSR_WIDTH       = 64;
   localparam int CSR_INDEX_WIDTH = 3;

   // plane word layout: nx, ny, nz, then distance, from bit 0 up
   localparam int PACK_WIDTH = 3 * NORMAL_WIDTH + COORD_WIDTH;
   localparam int EXT_WIDTH  = (PACK_WIDTH > CSR_WIDTH) ? PACK_WIDTH : CSR_WIDTH;

   localparam int PROD_WIDTH = NORMAL_WIDTH + COORD_WIDTH;
   // distance, radius and three products, all below 2^(PROD_WIDTH-1)
   localparam int SUM_WIDTH  = PROD_WIDTH + 3;

   localparam int VERDICT_WIDTH = 2;

   typedef logic [CSR_WIDTH-1:0]               csr_word_type;
   typedef csr_word_type [PLANE_COUNT-1:0]     plane_array_type;
   typedef logic signed [COORD_WIDTH-1:0]      coord_type;
   typedef logic signed [NORMAL_WIDTH-1:0]     normal_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_PLANE_TOP    = 3'd0,
      REG_PLANE_BOTTOM = 3'd1,
      REG_PLANE_LEFT   = 3'd2,
      REG_PLANE_RIGHT  = 3'd3,
      REG_PLANE_NEAR   = 3'd4,
      REG_PLANE_FAR    = 3'd5
   } csr_index_type;

   typedef enum logic [VERDICT_WIDTH-1:0] {
      VERDICT_INSIDE    = 2'd0,
      VERDICT_INTERSECT = 2'd1,
      VERDICT_OUTSIDE   = 2'd2
   } verdict_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0]  offset;
      logic signed [NORMAL_WIDTH-1:0] nz;
      logic signed [NORMAL_WIDTH-1:0] ny;
      logic signed [NORMAL_WIDTH-1:0] nx;
   } plane_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec_type;

   typedef struct packed {
      logic                    sphere;
      logic                    box_valid;
      vec_type                 lo;
      vec_type                 hi;
      vec_type                 center;
      logic [RADIUS_WIDTH-1:0] radius;
   } volume_type;

   typedef struct packed {
      logic pc_neg;   // positive corner (or sphere) outside
      logic nc_neg;   // negative corner outside
   } plane_flags_type;

   typedef plane_flags_type [PLANE_COUNT-1:0] flags_array_type;

   // bits above the 64-bit word read as zero
   function automatic plane_type unpack_plane(input csr_word_type word);
      logic [EXT_WIDTH-1:0] ext;
      plane_type            pl;
      ext       = EXT_WIDTH'(word);
      pl.nx     = ext[0 +: NORMAL_WIDTH];
      pl.ny     = ext[NORMAL_WIDTH +: NORMAL_WIDTH];
      pl.nz     = ext[2*NORMAL_WIDTH +: NORMAL_WIDTH];
      pl.offset = ext[3*NORMAL_WIDTH +: COORD_WIDTH];
      return pl;
   endfunction

endpackage

/* hdl/fvc_plane_regs.sv */
// ----------------------------------------------------------------------------
// fvc_plane_regs: frustum plane register file
// Six 64-bit plane words, written through the CSR port, cleared by reset.
// ----------------------------------------------------------------------------
module fvc_plane_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [fvc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  fvc_pkg::csr_word_type                csr_wdata,
   output fvc_pkg::plane_array_type             planes
);
   import fvc_pkg::*;

   plane_array_type planes_ff;
   plane_array_type planes_in;

   always_comb begin
      planes_in = planes_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_PLANE_TOP:    planes_in[REG_PLANE_TOP]    = csr_wdata;
            REG_PLANE_BOTTOM: planes_in[REG_PLANE_BOTTOM] = csr_wdata;
            REG_PLANE_LEFT:   planes_in[REG_PLANE_LEFT]   = csr_wdata;
            REG_PLANE_RIGHT:  planes_in[REG_PLANE_RIGHT]  = csr_wdata;
            REG_PLANE_NEAR:   planes_in[REG_PLANE_NEAR]   = csr_wdata;
            REG_PLANE_FAR:    planes_in[REG_PLANE_FAR]    = csr_wdata;
            default: ;        // unknown index: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff <= '0;
      end else begin
         planes_ff <= planes_in;
      end
   end

   assign planes = planes_ff;

endmodule

/* hdl/fvc_plane_eval.sv */
// ----------------------------------------------------------------------------
// fvc_plane_eval: one plane test lane
// Corner pick and products (stage 1), sums and sign flags (stage 2).
// ----------------------------------------------------------------------------
module fvc_plane_eval (
   input  logic                      clock,
   input  fvc_pkg::csr_word_type     plane_word,
   input  fvc_pkg::volume_type       volume,
   output fvc_pkg::plane_flags_type  flags
);
   import fvc_pkg::*;

   plane_type  pl;
   normal_type nrm [AXIS_COUNT];
   coord_type  lo  [AXIS_COUNT];
   coord_type  hi  [AXIS_COUNT];
   coord_type  ctr [AXIS_COUNT];

   logic signed [PROD_WIDTH-1:0] pc_prod_in [AXIS_COUNT];
   logic signed [PROD_WIDTH-1:0] nc_prod_in [AXIS_COUNT];
   logic signed [PROD_WIDTH-1:0] pc_prod_ff [AXIS_COUNT];
   logic signed [PROD_WIDTH-1:0] nc_prod_ff [AXIS_COUNT];
   logic signed [SUM_WIDTH-1:0]  bias_in;
   logic signed [SUM_WIDTH-1:0]  bias_ff;
   logic signed [SUM_WIDTH-1:0]  pc_sum;
   logic signed [SUM_WIDTH-1:0]  nc_sum;
   plane_flags_type              flags_in;
   plane_flags_type              flags_ff;

   always_comb begin
      pl     = unpack_plane(plane_word);
      nrm[0] = pl.nx;
      nrm[1] = pl.ny;
      nrm[2] = pl.nz;
      lo[0]  = volume.lo.x;
      lo[1]  = volume.lo.y;
      lo[2]  = volume.lo.z;
      hi[0]  = volume.hi.x;
      hi[1]  = volume.hi.y;
      hi[2]  = volume.hi.z;
      ctr[0] = volume.center.x;
      ctr[1] = volume.center.y;
      ctr[2] = volume.center.z;
   end

   // zero normal counts as non-negative
   always_comb begin
      coord_type pc;
      coord_type nc;
      for (int k = 0; k < AXIS_COUNT; k++) begin
         pc = nrm[k][NORMAL_WIDTH-1] ? lo[k] : hi[k];
         nc = nrm[k][NORMAL_WIDTH-1] ? hi[k] : lo[k];
         if (volume.sphere) begin
            pc = ctr[k];
         end
         pc_prod_in[k] = PROD_WIDTH'(PROD_WIDTH'(nrm[k]) * PROD_WIDTH'(pc));
         nc_prod_in[k] = PROD_WIDTH'(PROD_WIDTH'(nrm[k]) * PROD_WIDTH'(nc));
      end
   end

   // sphere: n.c + d < -r  <=>  n.c + d + r < 0
   always_comb begin
      bias_in = $signed(SUM_WIDTH'(pl.offset) <<< NORMAL_FRAC);
      if (volume.sphere) begin
         bias_in = bias_in + $signed(SUM_WIDTH'(volume.radius) << NORMAL_FRAC);
      end
   end

   always_ff @(posedge clock) begin
      pc_prod_ff <= pc_prod_in;
      nc_prod_ff <= nc_prod_in;
      bias_ff    <= bias_in;
   end

   always_comb begin
      pc_sum = bias_ff + SUM_WIDTH'(pc_prod_ff[0]) + SUM_WIDTH'(pc_prod_ff[1])
               + SUM_WIDTH'(pc_prod_ff[2]);
      nc_sum = bias_ff + SUM_WIDTH'(nc_prod_ff[0]) + SUM_WIDTH'(nc_prod_ff[1])
               + SUM_WIDTH'(nc_prod_ff[2]);
      flags_in.pc_neg = pc_sum[SUM_WIDTH-1];
      flags_in.nc_neg = nc_sum[SUM_WIDTH-1];
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
   end

   assign flags = flags_ff;

endmodule

/* hdl/frustum_volume_cull.sv */
// ----------------------------------------------------------------------------
// frustum_volume_cull: box / sphere test against six frustum planes
// Classifies one bounding volume per item as inside, intersecting or outside.
// ----------------------------------------------------------------------------
//
//   channel   ports                        handshake
//   -------   --------------------------   ----------------------------------
//   request   req_*  (volume fields)       start && !busy at rising edge
//   response  rsp_verdict                  rsp_valid, one cycle, no stall
//   csr       csr_index, csr_wdata         csr_we at rising edge
//
// Pipeline of four register stages: input, products, plane sums/flags,
// verdict. One item is accepted every cycle while busy is low; the verdict
// shows on rsp_* once the item has passed through these stages in order.
// Each plane lane has a 12x28 multiplier per axis and corner, then a
// four-term sum (distance and radius are folded together beside the
// products) and a sign test.
// busy is high only while reset is held; reset clears the valid pipe and
// the plane registers (all-zero planes put every volume inside).
// The response side cannot stall, so the pipe never holds.
// ----------------------------------------------------------------------------
module frustum_volume_cull (
   input  logic                                  clock,
   input  logic                                  reset,
   // request
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_action,
   input  logic                                  req_box_valid,
   input  logic signed [fvc_pkg::COORD_WIDTH-1:0] req_box_min_x,
   input  logic signed [fvc_pkg::COORD_WIDTH-1:0] req_box_min_y,
   input  logic signed [fvc_pkg::COORD_WIDTH-1:0] req_box_min_z,
   input  logic signed [fvc_pkg::COORD_WIDTH-1:0] req_box_max_x,
   input  logic signed [fvc_pkg::COORD_WIDTH-1:0] req_box_max_y,
   input  logic signed [fvc_pkg::COORD_WIDTH-1:0] req_box_max_z,
   input  logic signed [fvc_pkg::COORD_WIDTH-1:0] req_center_x,
   input  logic signed [fvc_pkg::COORD_WIDTH-1:0] req_center_y,
   input  logic signed [fvc_pkg::COORD_WIDTH-1:0] req_center_z,
   input  logic [fvc_pkg::RADIUS_WIDTH-1:0]       req_sphere_radius,
   // response
   output logic                                  rsp_valid,
   output logic [fvc_pkg::VERDICT_WIDTH-1:0]     rsp_verdict,
   // csr
   input  logic                                  csr_we,
   input  logic [fvc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [fvc_pkg::CSR_WIDTH-1:0]         csr_wdata
);
   import fvc_pkg::*;

   logic            accept;
   volume_type      volume_in;
   volume_type      volume_ff;
   plane_array_type planes;
   flags_array_type flags;

   // valid and mode travel alongside the lane stages
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff;
   logic s1_sphere_ff, s2_sphere_ff;
   logic s1_bv_ff, s2_bv_ff;

   logic        any_pc_neg;
   logic        any_nc_neg;
   verdict_type verdict_in;
   verdict_type verdict_ff;
   logic        rsp_valid_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // --- stage 0: input register -------------------------------------------
   always_comb begin
      volume_in.sphere    = req_action;
      volume_in.box_valid = req_box_valid;
      volume_in.lo.x      = req_box_min_x;
      volume_in.lo.y      = req_box_min_y;
      volume_in.lo.z      = req_box_min_z;
      volume_in.hi.x      = req_box_max_x;
      volume_in.hi.y      = req_box_max_y;
      volume_in.hi.z      = req_box_max_z;
      volume_in.center.x  = req_center_x;
      volume_in.center.y  = req_center_y;
      volume_in.center.z  = req_center_z;
      volume_in.radius    = req_sphere_radius;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         volume_ff <= volume_in;
      end
   end

   // --- plane registers ----------------------------------------------------
   fvc_plane_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .planes    (planes)
   );

   // --- stages 1-2: one lane per plane ------------------------------------
   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
      fvc_plane_eval u_eval (
         .clock      (clock),
         .plane_word (planes[p]),
         .volume     (volume_ff),
         .flags      (flags[p])
      );
   end

   // --- stage 3: verdict ---------------------------------------------------
   // any positive corner out -> outside; else any negative corner out ->
   // intersecting (box only); empty box is always inside
   always_comb begin
      any_pc_neg = 1'b0;
      any_nc_neg = 1'b0;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         any_pc_neg = any_pc_neg | flags[p].pc_neg;
         any_nc_neg = any_nc_neg | flags[p].nc_neg;
      end
      if (!s2_sphere_ff && !s2_bv_ff) begin
         verdict_in = VERDICT_INSIDE;
      end else if (any_pc_neg) begin
         verdict_in = VERDICT_OUTSIDE;
      end else if (!s2_sphere_ff && any_nc_neg) begin
         verdict_in = VERDICT_INTERSECT;
      end else begin
         verdict_in = VERDICT_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      s1_sphere_ff <= volume_ff.sphere;
      s1_bv_ff     <= volume_ff.box_valid;
      s2_sphere_ff <= s1_sphere_ff;
      s2_bv_ff     <= s1_bv_ff;
      verdict_ff   <= verdict_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= accept;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

endmodule

/* hdl/fvc_checker.sv */
// ----------------------------------------------------------------------------
// fvc_checker: port-level checks for frustum_volume_cull
// Latency, verdict coding and mode rules seen on the top-level ports.
// ----------------------------------------------------------------------------
module fvc_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  req_action,
   input logic                                  req_box_valid,
   input logic                                  rsp_valid,
   input logic [fvc_pkg::VERDICT_WIDTH-1:0]     rsp_verdict
);
   import fvc_pkg::*;

   logic accept;
   assign accept = start && !busy;

   // every accepted item is answered on rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("no response four cycles after accept");

   // no response without a matching accepted item
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 4))
      else $error("response without matching accept");

   // empty box is inside
   a_empty_box: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_action && !req_box_valid) |-> ##4 (rsp_verdict == VERDICT_INSIDE))
      else $error("empty box not reported inside");

   // sphere test never intersects
   a_sphere_code: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action) |-> ##4 (rsp_verdict != VERDICT_INTERSECT))
      else $error("sphere reported intersecting");

   // only defined codes leave the block
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == VERDICT_INSIDE || rsp_verdict == VERDICT_INTERSECT
                     || rsp_verdict == VERDICT_OUTSIDE))
      else $error("undefined verdict code");

endmodule

bind frustum_volume_cull fvc_checker u_fvc_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_action    (req_action),
   .req_box_valid (req_box_valid),
   .rsp_valid     (rsp_valid),
   .rsp_verdict   (rsp_verdict)
);
